>>> rtl/dslt_pkg.sv
// Shared types and constants for the descriptor slot LRU table.
`default_nettype none

package dslt_pkg;

    localparam int DESC_W  = 31;
    localparam int FIELD_W = 6;

    typedef struct packed {
        logic signed [31:0] descriptor;
        logic               is_socket;
        logic               install_ok;
    } in_item_t;

    typedef struct packed {
        logic               mapped;
        logic [FIELD_W-1:0] slot;
        logic               hit;
        logic               install_req;
        logic [FIELD_W-1:0] install_slot;
        logic               clear_req;
        logic [FIELD_W-1:0] clear_slot;
        logic [DESC_W-1:0]  cleared_descriptor;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_LOOKUP = 3'b010,
        ST_UPDATE = 3'b100
    } state_t;

    // Recency chain operations, broadcast to every cell.
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_MOVE_FRONT,
        CELL_REMOVE,
        CELL_DROP_LAST
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     cmp_en;
    } lru_ctrl_t;

    // Free slot stack operations.
    typedef enum logic [1:0] {
        FREE_HOLD,
        FREE_POP,
        FREE_PUSH
    } free_op_t;

endpackage

`default_nettype wire

>>> rtl/descriptor_slot_lru_table_top.sv
// Top level of the descriptor slot LRU table: control, result register, cell chains.
//
// Usage:
//   s_valid/s_ready/s_data carry one request transaction (descriptor, socket
//   flag, install outcome). m_valid/m_ready/m_data carry one result transaction
//   per request. cfg_we/cfg_wdata write table_enable; write only while idle.
// Timing: an accepted request is compared in parallel in every cell in the
//   lookup state; the decision and chain shift follow in the update state,
//   which loads the result register.
// Overlap: each request runs the compare/update pair on the recency chain;
//   the next request is taken in the update cycle of the one before.
// Stall: the result register holds one transaction. While it is full and
//   m_ready is low, the pending update waits and s_ready stays low.
// Reset (aresetn low, synchronous): table empty, free stack holds all slots
//   with slot 0 on top, table_enable = 1, no result pending. No clearing pass.
// Structure: SLOTS recency cells (position 0 most recent) shift entries to
//   neighbors; SLOTS free-stack cells form a push/pop shift register.
`default_nettype none

module descriptor_slot_lru_table_top #(
    parameter int SLOTS = 64
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   s_valid,
    output logic                  s_ready,
    input  dslt_pkg::in_item_t    s_data,
    output logic                  m_valid,
    input  wire                   m_ready,
    output dslt_pkg::out_item_t   m_data,
    input  wire                   cfg_we,
    input  wire                   cfg_wdata
);

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);

    // Slot numbers are reported in the fixed 6-bit field width.
    function automatic logic [dslt_pkg::FIELD_W-1:0] to_field(input logic [SLOT_W-1:0] s);
        logic [SLOT_W+dslt_pkg::FIELD_W-1:0] t;
        t = {{dslt_pkg::FIELD_W{1'b0}}, s};
        return t[dslt_pkg::FIELD_W-1:0];
    endfunction

    dslt_pkg::state_t    state_reg, state_next;
    dslt_pkg::in_item_t  req_reg;
    dslt_pkg::out_item_t res_reg, res_next;
    logic                res_valid_reg;
    logic                enable_reg;
    logic [CNT_W-1:0]    free_cnt_reg, free_cnt_next;

    // recency chain wiring
    logic                        occ_vec   [SLOTS];
    logic [SLOT_W-1:0]           slot_arr  [SLOTS];
    logic [dslt_pkg::DESC_W-1:0] desc_arr  [SLOTS];
    logic [SLOTS-1:0]            match_vec;
    logic [SLOTS-1:0]            occ_bits;
    logic                        seen_chain [SLOTS+1];
    logic [SLOT_W-1:0]           sel_chain  [SLOTS+1];
    logic [SLOT_W-1:0]           free_val   [SLOTS];

    dslt_pkg::lru_ctrl_t         ctrl;
    dslt_pkg::cell_op_t          op_calc;
    dslt_pkg::free_op_t          fop_calc, fop;
    logic [SLOT_W-1:0]           front_slot;
    logic [SLOT_W-1:0]           push_slot;

    logic                        out_free, commit, s_acc;
    logic                        en, any_hit;
    logic [dslt_pkg::DESC_W-1:0] key;
    logic [SLOT_W-1:0]           hit_slot, top_free, lru_slot;

    assign key      = req_reg.descriptor[dslt_pkg::DESC_W-1:0];
    assign en       = enable_reg && !req_reg.descriptor[31];
    assign any_hit  = seen_chain[SLOTS];
    assign hit_slot = sel_chain[SLOTS];
    assign top_free = free_val[0];
    assign lru_slot = slot_arr[SLOTS-1];

    assign out_free = !res_valid_reg || m_ready;
    assign commit   = (state_reg == dslt_pkg::ST_UPDATE) && out_free;
    assign s_ready  = (state_reg == dslt_pkg::ST_IDLE) || commit;
    assign s_acc    = s_valid && s_ready;

    // Decision for the request under update.
    always_comb begin
        res_next   = '0;
        op_calc    = dslt_pkg::CELL_HOLD;
        fop_calc   = dslt_pkg::FREE_HOLD;
        front_slot = hit_slot;
        push_slot  = hit_slot;
        if (en) begin
            if (req_reg.is_socket) begin
                if (any_hit) begin
                    // socket drop: remove entry, return its slot
                    op_calc                     = dslt_pkg::CELL_REMOVE;
                    fop_calc                    = dslt_pkg::FREE_PUSH;
                    push_slot                   = hit_slot;
                    res_next.clear_req          = 1'b1;
                    res_next.clear_slot         = to_field(hit_slot);
                    res_next.cleared_descriptor = key;
                end
            end else if (any_hit) begin
                op_calc         = dslt_pkg::CELL_MOVE_FRONT;
                front_slot      = hit_slot;
                res_next.mapped = 1'b1;
                res_next.slot   = to_field(hit_slot);
                res_next.hit    = 1'b1;
            end else if (free_cnt_reg != '0) begin
                res_next.install_req  = 1'b1;
                res_next.install_slot = to_field(top_free);
                if (req_reg.install_ok) begin
                    op_calc         = dslt_pkg::CELL_INSERT;
                    fop_calc        = dslt_pkg::FREE_POP;
                    front_slot      = top_free;
                    res_next.mapped = 1'b1;
                    res_next.slot   = to_field(top_free);
                end
                // a failed install pops and pushes the same slot: no change
            end else begin
                // table full: evict least recent
                res_next.clear_req          = 1'b1;
                res_next.clear_slot         = to_field(lru_slot);
                res_next.cleared_descriptor = desc_arr[SLOTS-1];
                res_next.install_req        = 1'b1;
                res_next.install_slot       = to_field(lru_slot);
                if (req_reg.install_ok) begin
                    op_calc         = dslt_pkg::CELL_INSERT;
                    front_slot      = lru_slot;
                    res_next.mapped = 1'b1;
                    res_next.slot   = to_field(lru_slot);
                end else begin
                    op_calc   = dslt_pkg::CELL_DROP_LAST;
                    fop_calc  = dslt_pkg::FREE_PUSH;
                    push_slot = lru_slot;
                end
            end
        end
    end

    assign ctrl.op     = commit ? op_calc : dslt_pkg::CELL_HOLD;
    assign ctrl.cmp_en = (state_reg == dslt_pkg::ST_LOOKUP);
    assign fop         = commit ? fop_calc : dslt_pkg::FREE_HOLD;

    always_comb begin
        free_cnt_next = free_cnt_reg;
        case (fop)
            dslt_pkg::FREE_POP:  free_cnt_next = free_cnt_reg - CNT_W'(1);
            dslt_pkg::FREE_PUSH: free_cnt_next = free_cnt_reg + CNT_W'(1);
            default:             free_cnt_next = free_cnt_reg;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            dslt_pkg::ST_IDLE:   if (s_acc) state_next = dslt_pkg::ST_LOOKUP;
            dslt_pkg::ST_LOOKUP: state_next = dslt_pkg::ST_UPDATE;
            dslt_pkg::ST_UPDATE: begin
                if (commit) begin
                    state_next = s_acc ? dslt_pkg::ST_LOOKUP : dslt_pkg::ST_IDLE;
                end
            end
            default: state_next = dslt_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= dslt_pkg::ST_IDLE;
            res_valid_reg <= 1'b0;
            enable_reg    <= 1'b1;
            free_cnt_reg  <= CNT_W'(SLOTS);
        end else begin
            state_reg    <= state_next;
            free_cnt_reg <= free_cnt_next;
            if (cfg_we) begin
                enable_reg <= cfg_wdata;
            end
            if (commit) begin
                res_valid_reg <= 1'b1;
            end else if (m_ready) begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            req_reg <= s_data;
        end
        if (commit) begin
            res_reg <= res_next;
        end
    end

    assign m_valid = res_valid_reg;
    assign m_data  = res_reg;

    // ---------------- cell chains ----------------
    assign seen_chain[0] = 1'b0;
    assign sel_chain[0]  = '0;

    for (genvar i = 0; i < SLOTS; i++) begin : g_cell
        logic                        l_occ, r_occ;
        logic [SLOT_W-1:0]           l_slot, r_slot, l_free, r_free;
        logic [dslt_pkg::DESC_W-1:0] l_desc, r_desc;

        if (i == 0) begin : g_front
            assign l_occ  = 1'b1;
            assign l_slot = front_slot;
            assign l_desc = key;
            assign l_free = push_slot;
        end else begin : g_mid_l
            assign l_occ  = occ_vec[i-1];
            assign l_slot = slot_arr[i-1];
            assign l_desc = desc_arr[i-1];
            assign l_free = free_val[i-1];
        end

        if (i == SLOTS - 1) begin : g_back
            assign r_occ  = 1'b0;
            assign r_slot = '0;
            assign r_desc = '0;
            assign r_free = '0;
        end else begin : g_mid_r
            assign r_occ  = occ_vec[i+1];
            assign r_slot = slot_arr[i+1];
            assign r_desc = desc_arr[i+1];
            assign r_free = free_val[i+1];
        end

        dslt_lru_cell #(
            .SLOT_W (SLOT_W)
        ) u_lru_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .key        (key),
            .is_last    (i == SLOTS - 1),
            .left_occ   (l_occ),
            .left_slot  (l_slot),
            .left_desc  (l_desc),
            .right_occ  (r_occ),
            .right_slot (r_slot),
            .right_desc (r_desc),
            .seen_in    (seen_chain[i]),
            .sel_in     (sel_chain[i]),
            .seen_out   (seen_chain[i+1]),
            .sel_out    (sel_chain[i+1]),
            .match      (match_vec[i]),
            .occ        (occ_vec[i]),
            .slot       (slot_arr[i]),
            .desc       (desc_arr[i])
        );

        assign occ_bits[i] = occ_vec[i];

        dslt_free_cell #(
            .SLOT_W (SLOT_W)
        ) u_free_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .op        (fop),
            .init_slot (SLOT_W'(i)),
            .left_val  (l_free),
            .right_val (r_free),
            .val       (free_val[i])
        );
    end

`ifndef SYNTHESIS
    a_free_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        free_cnt_reg <= CNT_W'(SLOTS))
        else $error("free count above slot count");

    a_occ_count: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(occ_bits) == (SLOTS - int'(free_cnt_reg)))
        else $error("occupied cells and free count disagree");

    a_single_match: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == dslt_pkg::ST_UPDATE) |-> $onehot0(match_vec))
        else $error("descriptor present in more than one cell");

    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(res_valid_reg) |-> $past(state_reg == dslt_pkg::ST_UPDATE))
        else $error("result produced outside update");

    a_front_occ: assert property (@(posedge aclk) disable iff (!aresetn)
        (commit && res_next.mapped) |=> occ_bits[0])
        else $error("mapped request left front cell empty");
`endif

endmodule

`default_nettype wire

>>> rtl/dslt_lru_cell.sv
// One recency position of the LRU chain: occupancy, slot number and descriptor.
`default_nettype none

module dslt_lru_cell #(
    parameter int SLOT_W = 6
) (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  dslt_pkg::lru_ctrl_t            ctrl,
    input  wire  [dslt_pkg::DESC_W-1:0]    key,
    input  wire                            is_last,
    input  wire                            left_occ,
    input  wire  [SLOT_W-1:0]              left_slot,
    input  wire  [dslt_pkg::DESC_W-1:0]    left_desc,
    input  wire                            right_occ,
    input  wire  [SLOT_W-1:0]              right_slot,
    input  wire  [dslt_pkg::DESC_W-1:0]    right_desc,
    input  wire                            seen_in,
    input  wire  [SLOT_W-1:0]              sel_in,
    output logic                           seen_out,
    output logic [SLOT_W-1:0]              sel_out,
    output logic                           match,
    output logic                           occ,
    output logic [SLOT_W-1:0]              slot,
    output logic [dslt_pkg::DESC_W-1:0]    desc
);

    logic                        occ_reg,  occ_next;
    logic [SLOT_W-1:0]           slot_reg, slot_next;
    logic [dslt_pkg::DESC_W-1:0] desc_reg, desc_next;
    logic                        match_reg;

    always_comb begin
        occ_next  = occ_reg;
        slot_next = slot_reg;
        desc_next = desc_reg;
        case (ctrl.op)
            dslt_pkg::CELL_INSERT: begin
                occ_next  = left_occ;
                slot_next = left_slot;
                desc_next = left_desc;
            end
            dslt_pkg::CELL_MOVE_FRONT: begin
                // positions up to and including the hit shift back by one
                if (!seen_in) begin
                    occ_next  = left_occ;
                    slot_next = left_slot;
                    desc_next = left_desc;
                end
            end
            dslt_pkg::CELL_REMOVE: begin
                // close the gap from the matched position on
                if (seen_in || match_reg) begin
                    occ_next  = right_occ;
                    slot_next = right_slot;
                    desc_next = right_desc;
                end
            end
            dslt_pkg::CELL_DROP_LAST: begin
                if (is_last) begin
                    occ_next = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg   <= 1'b0;
            match_reg <= 1'b0;
        end else begin
            occ_reg <= occ_next;
            if (ctrl.cmp_en) begin
                match_reg <= occ_reg && (desc_reg == key);
            end
        end
    end

    always_ff @(posedge aclk) begin
        slot_reg <= slot_next;
        desc_reg <= desc_next;
    end

    assign seen_out = seen_in | match_reg;
    assign sel_out  = sel_in | (match_reg ? slot_reg : '0);
    assign match    = match_reg;
    assign occ      = occ_reg;
    assign slot     = slot_reg;
    assign desc     = desc_reg;

endmodule

`default_nettype wire

>>> rtl/dslt_free_cell.sv
// One entry of the shift-register free slot stack.
`default_nettype none

module dslt_free_cell #(
    parameter int SLOT_W = 6
) (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  dslt_pkg::free_op_t      op,
    input  wire  [SLOT_W-1:0]       init_slot,
    input  wire  [SLOT_W-1:0]       left_val,
    input  wire  [SLOT_W-1:0]       right_val,
    output logic [SLOT_W-1:0]       val
);

    logic [SLOT_W-1:0] val_reg, val_next;

    always_comb begin
        val_next = val_reg;
        case (op)
            dslt_pkg::FREE_POP:  val_next = right_val;
            dslt_pkg::FREE_PUSH: val_next = left_val;
            default:             val_next = val_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            val_reg <= init_slot;
        end else begin
            val_reg <= val_next;
        end
    end

    assign val = val_reg;

endmodule

`default_nettype wire

>>> bench/tb.sv
// Self-checking bench for the descriptor slot LRU table: directed and random request traffic.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS          = 64;
    localparam int DESC_W         = dslt_pkg::DESC_W;
    localparam int FIELD_W        = dslt_pkg::FIELD_W;
    localparam int SETTLE_CYCLES  = 4;      // quiet cycles before a register write
    localparam int TAIL_CYCLES    = 8;      // drain time after the last result
    localparam int WATCHDOG_LIMIT = 20000;  // cycles with no handshake at all

    // What the request driver does next: send a request, switch the idle
    // profile, hold off until the table has drained, or write table_enable.
    typedef enum logic [1:0] {
        ACT_XFER,
        ACT_PHASE,
        ACT_DRAIN,
        ACT_CFG
    } act_kind_t;

    typedef struct packed {
        act_kind_t          kind;
        dslt_pkg::in_item_t req;
        logic [6:0]         idle_pct;
        logic [6:0]         stall_pct;
        logic               enable;
    } stim_t;

    // ------------------------------------------------------------------
    // Clock, reset and DUT ports. Every input starts at a known value.
    // ------------------------------------------------------------------
    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_valid   = 1'b0;
    logic                s_ready;
    dslt_pkg::in_item_t  s_data    = '0;
    logic                m_valid;
    logic                m_ready   = 1'b0;
    dslt_pkg::out_item_t m_data;
    logic                cfg_we    = 1'b0;
    logic                cfg_wdata = 1'b1;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    descriptor_slot_lru_table_top #(
        .SLOTS (SLOTS)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    stim_t               stim_q[$];          // pending driver actions, filled up front
    dslt_pkg::out_item_t expected_q[$];      // predicted results, oldest first
    int        err_cnt       = 0;
    int        src_idle_pct  = 0;  // chance the sender stays idle in a cycle
    int        sink_stall_pct = 0; // chance the receiver drops m_ready
    int        settle_cnt    = SETTLE_CYCLES;
    int        quiet_cycles  = 0;

    // Shadow copy of the table: slot contents, recency list (index 0 is most
    // recent), LIFO of free slots and the enable register.
    logic [DESC_W-1:0]  slot_desc [0:SLOTS-1];
    logic               slot_vld  [0:SLOTS-1];
    logic [FIELD_W-1:0] lru_order [0:SLOTS-1];
    int                 lru_count;
    logic [FIELD_W-1:0] free_stk  [0:SLOTS-1];
    int                 free_cnt;
    logic               table_en;

    // Descriptor pool for random traffic: small numbers and wide random ones.
    logic [DESC_W-1:0]  desc_pool [0:127];

    function automatic void reset_shadow();
        int i;
        for (i = 0; i < SLOTS; i++) begin
            slot_desc[i] = '0;
            slot_vld[i]  = 1'b0;
            lru_order[i] = '0;
            free_stk[i]  = FIELD_W'(SLOTS - 1 - i);  // top of stack pops slot 0
        end
        lru_count = 0;
        free_cnt  = SLOTS;
        table_en  = 1'b1;
    endfunction

    // Close the gap at recency position pos.
    function automatic void drop_rank(int pos);
        int i;
        for (i = pos; i + 1 < lru_count; i++)
            lru_order[i] = lru_order[i + 1];
        lru_count--;
    endfunction

    // Make slot s the most recent entry.
    function automatic void promote_slot(logic [FIELD_W-1:0] s);
        int i;
        for (i = lru_count; i > 0; i--)
            lru_order[i] = lru_order[i - 1];
        lru_order[0] = s;
        lru_count++;
    endfunction

    // Return a slot to the free LIFO; a full stack ignores the push.
    function automatic void free_push(logic [FIELD_W-1:0] s);
        if (free_cnt < SLOTS) begin
            free_stk[free_cnt] = s;
            free_cnt++;
        end
    endfunction

    // Lookup/update for one accepted request; returns the slot decision.
    function automatic dslt_pkg::out_item_t predict_lookup(dslt_pkg::in_item_t req);
        dslt_pkg::out_item_t res;
        logic [DESC_W-1:0]   key;
        int                  pos;
        int                  i;
        logic [FIELD_W-1:0]  s;
        logic                have;
        logic                found;
        res   = '0;
        key   = req.descriptor[DESC_W-1:0];
        pos   = 0;
        found = 1'b0;
        have  = 1'b0;
        s     = '0;
        // Disabled table or negative descriptor: plain bypass.
        if (table_en && !req.descriptor[31]) begin
            for (i = 0; i < lru_count; i++) begin
                if (!found && slot_vld[lru_order[i]] && slot_desc[lru_order[i]] == key) begin
                    found = 1'b1;
                    pos   = i;
                end
            end
            if (req.is_socket) begin
                // Socket: drop any entry it holds and free its slot.
                if (found) begin
                    s = lru_order[pos];
                    slot_vld[s] = 1'b0;
                    drop_rank(pos);
                    free_push(s);
                    res.clear_req          = 1'b1;
                    res.clear_slot         = s;
                    res.cleared_descriptor = key;
                end
            end else if (found) begin
                // Hit: promote to most recent.
                s = lru_order[pos];
                drop_rank(pos);
                promote_slot(s);
                res.mapped = 1'b1;
                res.slot   = s;
                res.hit    = 1'b1;
            end else begin
                // Miss: free slot if any, else evict the least recent entry.
                if (free_cnt > 0) begin
                    free_cnt--;
                    s    = free_stk[free_cnt];
                    have = 1'b1;
                end else if (lru_count > 0) begin
                    s = lru_order[lru_count - 1];
                    res.clear_req          = 1'b1;
                    res.clear_slot         = s;
                    res.cleared_descriptor = slot_desc[s];
                    slot_vld[s] = 1'b0;
                    have        = 1'b1;
                    lru_count--;
                end
                if (have) begin
                    res.install_req  = 1'b1;
                    res.install_slot = s;
                    if (req.install_ok && lru_count < SLOTS) begin
                        slot_desc[s] = key;
                        slot_vld[s]  = 1'b1;
                        promote_slot(s);
                        res.mapped = 1'b1;
                        res.slot   = s;
                    end else begin
                        // Failed install: slot goes back on the stack.
                        free_push(s);
                    end
                end
            end
        end
        return res;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            err_cnt++;
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------
    task automatic add_req(logic signed [31:0] desc, logic sock, logic ok);
        stim_t st;
        st                = '0;
        st.kind           = ACT_XFER;
        st.req.descriptor = desc;
        st.req.is_socket  = sock;
        st.req.install_ok = ok;
        stim_q.insert(stim_q.size(), st);
    endtask

    task automatic add_phase(int idle, int stall);
        stim_t st;
        st           = '0;
        st.kind      = ACT_PHASE;
        st.idle_pct  = 7'(idle);
        st.stall_pct = 7'(stall);
        stim_q.insert(stim_q.size(), st);
    endtask

    task automatic add_ctrl(act_kind_t kind, logic en);
        stim_t st;
        st        = '0;
        st.kind   = kind;
        st.enable = en;
        stim_q.insert(stim_q.size(), st);
    endtask

    // Mostly well-formed descriptors from a pool of pool_lim entries, so the
    // table fills, hits and evicts; a few negative or fully random values.
    task automatic add_random(int n, int pool_lim);
        int                 k;
        int                 r;
        logic signed [31:0] desc;
        for (k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 5)
                desc = $urandom | 32'h8000_0000;
            else if (r < 8)
                desc = $urandom;
            else
                desc = {1'b0, desc_pool[$urandom_range(0, pool_lim - 1)]};
            add_req(desc, $urandom_range(0, 99) < 10, $urandom_range(0, 99) < 90);
        end
    endtask

    // ------------------------------------------------------------------
    // Request driver. One nonblocking update per signal per edge: the next
    // values are worked out first, then applied once at the bottom.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : drv
        logic               nxt_valid;
        dslt_pkg::in_item_t nxt_req;
        logic               nxt_we;
        logic               nxt_wdata;
        stim_t              cur;
        nxt_valid = s_valid;
        nxt_req   = s_data;
        nxt_we    = 1'b0;
        nxt_wdata = cfg_wdata;
        if (!aresetn) begin
            nxt_valid = 1'b0;
        end else begin
            // Request transaction taken: predict its result right away.
            if (s_valid && s_ready) begin
                expected_q.insert(expected_q.size(), predict_lookup(s_data));
                nxt_valid = 1'b0;
            end
            if (!nxt_valid && stim_q.size() > 0) begin
                case (stim_q[0].kind)
                    ACT_XFER: begin
                        if ($urandom_range(0, 99) >= src_idle_pct) begin
                            cur       = stim_q.pop_front();
                            nxt_valid = 1'b1;
                            nxt_req   = cur.req;
                        end
                    end
                    ACT_PHASE: begin
                        cur            = stim_q.pop_front();
                        src_idle_pct   = int'(cur.idle_pct);
                        sink_stall_pct = int'(cur.stall_pct);
                    end
                    default: begin
                        // Drain and register write both wait for an empty
                        // table pipeline, then a few quiet cycles.
                        if (expected_q.size() != 0) begin
                            settle_cnt = SETTLE_CYCLES;
                        end else if (settle_cnt > 0) begin
                            settle_cnt--;
                        end else begin
                            cur        = stim_q.pop_front();
                            settle_cnt = SETTLE_CYCLES;
                            if (cur.kind == ACT_CFG) begin
                                nxt_we    = 1'b1;
                                nxt_wdata = cur.enable;
                                table_en  = cur.enable;
                            end
                        end
                    end
                endcase
            end
        end
        s_valid   <= nxt_valid;
        s_data    <= nxt_req;
        cfg_we    <= nxt_we;
        cfg_wdata <= nxt_wdata;
    end

    // ------------------------------------------------------------------
    // Result monitor: compare each result transaction with the oldest
    // prediction, and throttle m_ready per the current stall profile.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : mon
        dslt_pkg::out_item_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    $error("result transaction with no request outstanding");
                    err_cnt++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("mapped", 32'(want.mapped), 32'(m_data.mapped));
                    check_field("slot", 32'(want.slot), 32'(m_data.slot));
                    check_field("hit", 32'(want.hit), 32'(m_data.hit));
                    check_field("install_req", 32'(want.install_req),
                                32'(m_data.install_req));
                    check_field("install_slot", 32'(want.install_slot),
                                32'(m_data.install_slot));
                    check_field("clear_req", 32'(want.clear_req), 32'(m_data.clear_req));
                    check_field("clear_slot", 32'(want.clear_slot), 32'(m_data.clear_slot));
                    check_field("cleared_descriptor", 32'(want.cleared_descriptor),
                                32'(m_data.cleared_descriptor));
                end
            end
            m_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    // Watchdog: a long stretch with no handshake means the block is hung.
    always @(posedge aclk) begin : wdog
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : stim
        int i;
        reset_shadow();
        for (i = 0; i < 128; i++)
            desc_pool[i] = (i % 2) ? DESC_W'($urandom) : DESC_W'(i);

        // Directed: first pop takes slot 0, hit, top descriptor, negatives,
        // failed install, socket drop present/absent, disabled bypass.
        add_phase(0, 0);
        add_req(32'sd0, 1'b0, 1'b1);
        add_req(32'sd0, 1'b0, 1'b1);
        add_req(32'sh7FFF_FFFF, 1'b0, 1'b1);
        add_req(-32'sd1, 1'b0, 1'b1);
        add_req(32'sh8000_0000, 1'b1, 1'b1);
        add_req(32'sd5, 1'b0, 1'b0);
        add_req(32'sd5, 1'b0, 1'b1);
        add_req(32'sd5, 1'b1, 1'b0);
        add_req(32'sd1234, 1'b1, 1'b1);
        add_req(32'sh7FFF_FFFF, 1'b0, 1'b0);
        add_req(32'sh5555_5555, 1'b0, 1'b1);
        add_req(32'sh2AAA_AAAA, 1'b0, 1'b1);
        add_ctrl(ACT_CFG, 1'b0);
        add_req(32'sd0, 1'b0, 1'b1);
        add_req(32'sh7FFF_FFFF, 1'b1, 1'b1);
        add_req(-32'sd1, 1'b0, 1'b0);
        add_ctrl(ACT_CFG, 1'b1);
        add_req(32'sd0, 1'b1, 1'b1);
        add_req(32'sh7FFF_FFFF, 1'b0, 1'b1);

        // Random phases. Small pool: mostly hits; larger pools: evictions.
        add_random(200, 40);
        add_ctrl(ACT_DRAIN, 1'b0);           // sender holds until all results are back
        add_phase(76, 0);
        add_random(200, 100);
        add_ctrl(ACT_CFG, 1'b0);
        add_phase(0, 76);
        add_random(50, 100);
        add_ctrl(ACT_CFG, 1'b1);
        add_random(250, 128);
        add_ctrl(ACT_DRAIN, 1'b0);
        add_phase(23, 23);
        add_random(250, 80);
        add_ctrl(ACT_CFG, 1'b1);
        add_phase(0, 0);
        add_random(50, 70);

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Wait for every request to go out and every result to come back.
        while (stim_q.size() != 0 || s_valid || expected_q.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (err_cnt == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire
